>>> src/rsd_pkg.sv
// Shared types, constants and helpers for the readout stream decoder.
package rsd_pkg;

    typedef enum logic [4:0] {
        KIND_PKT_HDR  = 5'd0,
        KIND_PKT_TAIL = 5'd1,
        KIND_HDR_FIRST = 5'd2,
        KIND_HDR_LAST = 5'd13,
        KIND_CHAN     = 5'd14,
        KIND_TIME     = 5'd15,
        KIND_ADC      = 5'd16,
        KIND_HUFF     = 5'd17,
        KIND_TAIL     = 5'd18,
        KIND_UNKNOWN  = 5'd19
    } kind_e;

    localparam logic [31:0] PKT_HDR_WORD  = 32'hFFFF_FFFF;
    localparam logic [31:0] PKT_TAIL_WORD = 32'hE000_0000;
    localparam int unsigned HUFF_BITS = 15;

    typedef struct packed {
        logic [4:0]  word_kind;
        logic [5:0]  channel;
        logic [11:0] sample;
        logic        sample_valid;
        logic        format_violation;
        logic        bad_frame;
        logic        huffman_error;
        logic        module_closed;
        logic        checksum_match;
        logic        module_full;
        logic [4:0]  slot;
        logic        last;
    } result_t;

    // Front-to-back item: one classified half or packet word
    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] half;
        logic        viol;
        logic        is_last;
    } item_t;

    function automatic logic [19:0] allowed_prev(input logic [4:0] k);
        logic [19:0] r;
        r = '0;
        unique case (k)
            5'd0:  r = 20'h00002;
            5'd1:  r = 20'h74000;
            5'd2:  r = 20'h74001;
            5'd3:  r[2] = 1'b1;
            5'd4:  r[3] = 1'b1;
            5'd5:  r[4] = 1'b1;
            5'd6:  r[5] = 1'b1;
            5'd7:  r[6] = 1'b1;
            5'd8:  r[7] = 1'b1;
            5'd9:  r[8] = 1'b1;
            5'd10: r[9] = 1'b1;
            5'd11: r[10] = 1'b1;
            5'd12: r[11] = 1'b1;
            5'd13: r[12] = 1'b1;
            5'd14: r = 20'h46000;
            5'd15: r = 20'h44000;
            5'd16: r = 20'h3C000;
            5'd17: r = 20'h30000;
            5'd18: r = 20'h30000;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic violates(input logic [4:0] k, input logic [4:0] p);
        logic [19:0] a;
        a = allowed_prev(k);
        if (p > 5'd19)
            return 1'b1;
        return ~a[p];
    endfunction

endpackage

>>> src/rsd_front.sv
// Front end: splits words into halves, runs the header counter and checks kind order.
module rsd_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [31:0]    s_tdata,
    output logic           q_valid,
    input  logic           q_ready,
    output rsd_pkg::item_t q_item
);
    import rsd_pkg::*;

    logic [31:0] word_reg, word_next;
    logic        busy_reg, busy_next;
    logic        phase_reg, phase_next;
    logic [3:0]  step_reg, step_next;
    logic [4:0]  prev_reg, prev_next;

    logic        is_phdr, is_ptail;
    logic [15:0] h;
    logic [4:0]  kind;
    logic        viol;

    assign s_tready = !busy_reg || (q_ready && (phase_reg || is_phdr || is_ptail));
    assign is_phdr  = word_reg == PKT_HDR_WORD;
    assign is_ptail = word_reg == PKT_TAIL_WORD;
    assign h        = phase_reg ? word_reg[31:16] : word_reg[15:0];

    always_comb
    begin
        step_next = step_reg;
        if (is_phdr)
            kind = KIND_PKT_HDR;
        else if (is_ptail)
            kind = KIND_PKT_TAIL;
        else if (h == 16'hFFFF && !phase_reg && step_reg == 4'd0)
        begin
            kind = KIND_HDR_FIRST;
            step_next = 4'd1;
        end
        else if (h[15:12] == 4'hF && step_reg > 4'd0 && step_reg < 4'd12
                 && step_reg[0] == phase_reg)
        begin
            kind = KIND_HDR_FIRST + {1'b0, step_reg};
            step_next = (step_reg == 4'd11) ? 4'd0 : step_reg + 4'd1;
        end
        else
        begin
            step_next = 4'd0;
            if (h[15:12] == 4'h1)
                kind = KIND_CHAN;
            else if (h[15:14] == 2'b01)
                kind = KIND_TIME;
            else if (h[15:12] == 4'h2)
                kind = KIND_ADC;
            else if (h[15])
                kind = KIND_HUFF;
            else if (h[15:12] == 4'h3)
                kind = KIND_TAIL;
            else
                kind = KIND_UNKNOWN;
        end
        viol = violates(kind, prev_reg);
        prev_next = prev_reg;
        // Out-of-order module header words after the first leave the previous kind alone
        if (!(kind > KIND_HDR_FIRST && kind <= KIND_HDR_LAST && viol))
            prev_next = kind;
    end

    assign q_valid = busy_reg;
    assign q_item  = '{kind: kind, half: h, viol: viol,
                       is_last: phase_reg || is_phdr || is_ptail};

    always_comb
    begin
        word_next  = word_reg;
        busy_next  = busy_reg;
        phase_next = phase_reg;
        if (busy_reg && q_ready)
        begin
            if (q_item.is_last)
                busy_next = 1'b0;
            else
                phase_next = 1'b1;
        end
        if (s_tvalid && s_tready)
        begin
            word_next  = s_tdata;
            busy_next  = 1'b1;
            phase_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            step_reg  <= 4'd0;
            prev_reg  <= KIND_UNKNOWN;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            if (busy_reg && q_ready)
            begin
                step_reg <= is_phdr || is_ptail ? step_reg : step_next;
                prev_reg <= prev_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

endmodule

>>> src/rsd_queue.sv
// Two-entry queue between the front and back ends.
module rsd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rsd_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output rsd_pkg::item_t out_item
);
    import rsd_pkg::*;

    item_t       mem_reg [2];
    logic        wptr_reg, rptr_reg;
    logic [1:0]  count_reg;
    logic        push, pop;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_item  = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= ~wptr_reg;
            if (pop)
                rptr_reg <= ~rptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= in_item;
    end

endmodule

>>> src/rsd_back.sv
// Back end: decodes items, keeps module state and expands compressed samples.
module rsd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_ready,
    input  rsd_pkg::item_t  q_item,
    output logic            m_valid,
    input  logic            m_ready,
    output rsd_pkg::result_t m_result
);
    import rsd_pkg::*;

    logic        done_reg;
    logic [4:0]  slot_reg;
    logic [23:0] frame_reg, hsum_reg, rsum_reg;
    logic [11:0] last_reg;
    logic [5:0]  chan_reg;
    logic        cip_reg;

    // Huffman expansion: pending one-bits scanned from bit 0 upward
    logic        hbusy_reg;
    logic [14:0] hbits_reg;
    item_t       hitem_reg;

    result_t     out_reg;
    logic        oval_reg;
    logic        can_emit;

    assign can_emit = !oval_reg || m_ready;
    assign m_valid  = oval_reg;
    assign m_result = out_reg;
    assign q_ready  = can_emit && !hbusy_reg;

    // Lowest pending one-bit and the zero run above it
    logic [3:0]  lo_pos;
    logic        found;
    logic [3:0]  zrun;
    logic [14:0] rest;
    logic [11:0] diff;
    logic        herr;
    always_comb
    begin
        lo_pos = 4'd0;
        for (int i = HUFF_BITS - 1; i >= 0; i--)
            if (hbits_reg[i])
                lo_pos = 4'(i);
        rest = hbits_reg & ~(15'd1 << lo_pos);
        // zeros above this one-bit count up to next higher one-bit
        zrun = 4'd0;
        found = 1'b0;
        for (int k = 0; k < HUFF_BITS; k++)
            if (4'(k) > lo_pos && hitem_reg.half[k] && !found)
            begin
                zrun  = 4'(k) - lo_pos - 4'd1;
                found = 1'b1;
            end
        if (!found)
            zrun = 4'd14 - lo_pos;
        herr = zrun > 4'd6;
        if (herr)
            diff = 12'd0;
        else if (zrun[0])
            diff = 12'd0 - 12'({1'b0, zrun[3:1]} + 4'd1);
        else
            diff = 12'({1'b0, zrun[3:1]});
    end

    logic [23:0] lo24, hi24;
    assign lo24 = {12'd0, q_item.half[11:0]};
    assign hi24 = {q_item.half[11:0], 12'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            slot_reg  <= 5'd0;
            frame_reg <= 24'd0;
            hsum_reg  <= 24'd0;
            rsum_reg  <= 24'd0;
            last_reg  <= 12'd0;
            chan_reg  <= 6'd0;
            cip_reg   <= 1'b0;
            hbusy_reg <= 1'b0;
            hbits_reg <= 15'd0;
            hitem_reg <= '0;
            out_reg   <= '0;
            oval_reg  <= 1'b0;
        end
        else if (can_emit)
        begin
            if (hbusy_reg)
            begin
                logic [11:0] ns;
                ns = last_reg + diff;
                last_reg  <= ns;
                hbits_reg <= rest;
                hbusy_reg <= rest != 15'd0;
                oval_reg  <= 1'b1;
                out_reg   <= '{word_kind: KIND_HUFF, channel: chan_reg, sample: ns,
                               sample_valid: 1'b1, format_violation: hitem_reg.viol,
                               bad_frame: 1'b0, huffman_error: herr,
                               module_closed: 1'b0, checksum_match: 1'b0,
                               module_full: 1'b0, slot: slot_reg,
                               last: hitem_reg.is_last && rest == 15'd0};
            end
            else if (q_valid)
            begin
                result_t r;
                logic    hdr_ok;
                r = '{word_kind: q_item.kind, channel: chan_reg, sample: 12'd0,
                      sample_valid: 1'b0, format_violation: q_item.viol,
                      bad_frame: 1'b0, huffman_error: 1'b0, module_closed: 1'b0,
                      checksum_match: 1'b0, module_full: 1'b0, slot: slot_reg,
                      last: q_item.is_last};
                hdr_ok = !q_item.viol;
                oval_reg <= !(q_item.kind == KIND_HUFF && q_item.half[14:0] != 15'd0);
                if (q_item.kind == KIND_PKT_HDR)
                begin
                    r.module_closed  = cip_reg;
                    r.checksum_match = cip_reg && hsum_reg == rsum_reg;
                    r.slot = cip_reg ? slot_reg : 5'd0;
                    slot_reg <= 5'd0;
                    frame_reg <= 24'd0;
                    hsum_reg <= 24'd0;
                    rsum_reg <= 24'd0;
                    last_reg <= 12'd0;
                    done_reg <= 1'b0;
                    cip_reg  <= 1'b0;
                end
                else if (q_item.kind == KIND_PKT_TAIL)
                begin
                end
                else if (q_item.kind == KIND_HDR_FIRST)
                begin
                    if (done_reg)
                    begin
                        r.module_closed  = 1'b1;
                        r.checksum_match = hsum_reg == rsum_reg;
                        slot_reg <= 5'd0;
                        frame_reg <= 24'd0;
                        hsum_reg <= 24'd0;
                        rsum_reg <= 24'd0;
                        last_reg <= 12'd0;
                        done_reg <= 1'b0;
                        cip_reg  <= 1'b1;
                    end
                end
                else if (q_item.kind <= KIND_HDR_LAST)
                begin
                    if (hdr_ok)
                    begin
                        unique case (q_item.kind)
                            5'd3:
                            begin
                                slot_reg <= q_item.half[4:0];
                                r.slot = q_item.half[4:0];
                                r.module_full = q_item.half[11];
                            end
                            5'd8:  frame_reg <= frame_reg + hi24;
                            5'd9:  frame_reg <= frame_reg + lo24;
                            5'd10: hsum_reg <= hsum_reg + hi24;
                            5'd11: hsum_reg <= hsum_reg + lo24;
                            5'd13: done_reg <= 1'b1;
                            default: ;
                        endcase
                    end
                end
                else
                begin
                    rsum_reg <= rsum_reg + {8'd0, q_item.half};
                    if (q_item.kind == KIND_CHAN)
                    begin
                        chan_reg <= q_item.half[5:0];
                        r.channel = q_item.half[5:0];
                        r.bad_frame = q_item.half[11:6] != frame_reg[5:0];
                        last_reg <= 12'd0;
                    end
                    else if (q_item.kind == KIND_ADC || q_item.kind == KIND_TAIL)
                    begin
                        last_reg <= q_item.half[11:0];
                        r.sample = q_item.half[11:0];
                        r.sample_valid = 1'b1;
                    end
                    else if (q_item.kind == KIND_HUFF && q_item.half[14:0] != 15'd0)
                    begin
                        hbusy_reg <= 1'b1;
                        hbits_reg <= q_item.half[14:0];
                        hitem_reg <= q_item;
                    end
                end
                out_reg <= r;
            end
            else
                oval_reg <= 1'b0;
        end
    end

endmodule

>>> src/readout_stream_decoder_core.sv
// Top level of the readout stream decoder.
// A word is held in the front end register, queued, and its first result is registered in the
// back end output; a compressed low half with one-bits first loads the expansion registers.
// Each split word yields two queue items and each packet word one; a compressed half with
// one-bits yields one result per sample from the back end loop, which holds off the queue.
// Reset: rst_n asynchronous, clears header counter, module state and queue.
module readout_stream_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // data_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // channel, sample, sample_valid,
                                    // format_violation, bad_frame, huffman_error,
                                    // module_closed, checksum_match, module_full,
                                    // slot, zero pad
    output logic [4:0]  m_tuser,    // word_kind
    output logic        m_tlast
);
    import rsd_pkg::*;

    logic    fq_valid, fq_ready, qb_valid, qb_ready;
    item_t   fq_item, qb_item;
    result_t res;

    rsd_front u_front (
        .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .q_valid(fq_valid), .q_ready(fq_ready), .q_item(fq_item)
    );

    rsd_queue u_queue (
        .clk(clk), .rst_n(rst_n), .in_valid(fq_valid), .in_ready(fq_ready),
        .in_item(fq_item), .out_valid(qb_valid), .out_ready(qb_ready),
        .out_item(qb_item)
    );

    rsd_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(qb_valid), .q_ready(qb_ready),
        .q_item(qb_item), .m_valid(m_tvalid), .m_ready(m_tready), .m_result(res)
    );

    assign m_tdata = {2'd0, res.slot, res.module_full, res.checksum_match,
                      res.module_closed, res.huffman_error, res.bad_frame,
                      res.format_violation, res.sample_valid, res.sample,
                      res.channel};
    assign m_tuser = res.word_kind;
    assign m_tlast = res.last;

endmodule

>>> src/rsd_checker.sv
// Port-level checks for the readout stream decoder.
module rsd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [4:0]  m_tuser,
    input logic        m_tlast
);
    import rsd_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output changed while stalled");
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= KIND_UNKNOWN)
        else $error("kind out of range");
    a_samp: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[18] |-> m_tdata[17:6] == 12'd0)
        else $error("sample without valid");
    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[23] |-> m_tdata[22])
        else $error("match without closure");
    a_plast: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser <= KIND_PKT_TAIL |-> m_tlast)
        else $error("packet word result not last");
endmodule

bind readout_stream_decoder_core rsd_checker u_rsd_checker (
    .clk(clk), .rst_n(rst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);
